>>> src/bcfh_pkg.sv
// bcfh_pkg: shared types and constants for the boiler call-for-heat controller
// no dependencies; imported by bcfh_threshold and boiler_call_for_heat_controller

package bcfh_pkg;

   // csr register indexes
   localparam int unsigned CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_ON_MINUTES   = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_TICKS_PER_MINUTE = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LOW_THRESHOLD_PC = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MODERATE_OPEN_PC = 8'd3;
   localparam int unsigned CsrDataWidth = 8;

   // item kinds
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // fixed widths
   localparam int unsigned IdWidth        = 16;
   localparam int unsigned PercentWidth   = 7;
   localparam int unsigned CountdownWidth = 14;
   localparam int unsigned MinuteWidth    = 8;

   // window and off-minute limits
   localparam logic [5:0] WINDOW_PAUSE_END     = 6'd15;
   localparam logic [5:0] WINDOW_ENCOURAGE_END = 6'd31;
   localparam logic [MinuteWidth-1:0] OFF_CAP  = 8'd254;
   localparam logic [MinuteWidth-1:0] OFF_MAX  = 8'd255;

   typedef struct packed {
      logic [7:0]              min_on_minutes;
      logic [5:0]              ticks_per_minute;
      logic [PercentWidth-1:0] low_threshold_pc;
      logic [PercentWidth-1:0] moderate_open_pc;
   } cfg_type;

endpackage

>>> src/boiler_call_for_heat_controller.sv
// boiler_call_for_heat_controller: boiler hub top level
// path: an accepted request waits in the input register, and the result register loads
// from it when it advances, which a held result register can delay
// throughput: one transaction per cycle; the input register feeds the result register
// through one pass of update logic, stalls only when the result register is held
// reset: synchronous active-high; clears state, csr registers to defaults, both valids
// depends on bcfh_pkg and bcfh_threshold

module boiler_call_for_heat_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_kind,
   input  logic [bcfh_pkg::IdWidth-1:0]           req_caller_id,
   input  logic [bcfh_pkg::PercentWidth-1:0]      req_percent_open,
   input  logic                                   req_minute_start,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_boiler_on,
   output logic                                   rsp_call_latched,
   output logic                                   rsp_call_heard,
   output logic                                   rsp_call_ignored,
   output logic [bcfh_pkg::IdWidth-1:0]           rsp_heard_id,
   output logic                                   rsp_switched_off,
   // csr write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bcfh_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [bcfh_pkg::CsrDataWidth-1:0]      csr_wdata
);
   import bcfh_pkg::*;

   // ---------------------------------------------------------------
   // csr registers, always ready
   // ---------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_ON_MINUTES:   cfg_in.min_on_minutes   = csr_wdata;
            CSR_TICKS_PER_MINUTE: cfg_in.ticks_per_minute = csr_wdata[5:0];
            CSR_LOW_THRESHOLD_PC: cfg_in.low_threshold_pc = csr_wdata[PercentWidth-1:0];
            CSR_MODERATE_OPEN_PC: cfg_in.moderate_open_pc = csr_wdata[PercentWidth-1:0];
            default: ; // unknown index is dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // input register
   // ---------------------------------------------------------------
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_kind_ff;
   logic [IdWidth-1:0]      s1_caller_id_ff;
   logic [PercentWidth-1:0] s1_percent_ff;
   logic                    s1_minute_start_ff;

   logic advance;   // item in the input register is processed this cycle
   logic req_fire;

   assign advance   = s1_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in = req_fire || (s1_valid_ff && !advance);

   // ---------------------------------------------------------------
   // controller state
   // ---------------------------------------------------------------
   logic                      pending_call_ff, pending_call_in;
   logic [IdWidth-1:0]        pending_id_ff, pending_id_in;
   logic [CountdownWidth-1:0] on_countdown_ff, on_countdown_in;
   logic [MinuteWidth-1:0]    off_minutes_ff, off_minutes_in;
   logic [MinuteWidth-1:0]    minute_count_ff, minute_count_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               boiler_on_ff, boiler_on_in;
   logic               call_latched_ff, call_latched_in;
   logic               call_heard_ff, call_heard_in;
   logic               call_ignored_ff, call_ignored_in;
   logic [IdWidth-1:0] heard_id_ff, heard_id_in;
   logic               switched_off_ff, switched_off_in;

   // report threshold depends on window and whether the boiler runs
   logic [PercentWidth-1:0] threshold;

   bcfh_threshold u_threshold (
      .cfg          (cfg_ff),
      .minute_count (minute_count_ff),
      .boiler_on    (on_countdown_ff != '0),
      .threshold    (threshold)
   );

   // on-time load in ticks, 8 x 6 bits fits the 14-bit countdown
   logic [CountdownWidth-1:0] on_load;
   logic [MinuteWidth-1:0]    off_limit;

   assign on_load = CountdownWidth'(cfg_ff.min_on_minutes)
                  * CountdownWidth'(cfg_ff.ticks_per_minute);
   // limit capped so a 255 minimum still lets the boiler start
   assign off_limit = (cfg_ff.min_on_minutes < OFF_CAP) ? cfg_ff.min_on_minutes : OFF_CAP;

   // single-pass item update
   always_comb begin
      logic                      ignore;
      logic [CountdownWidth-1:0] countdown_mid;
      logic [MinuteWidth-1:0]    off_mid;

      ignore          = 1'b0;
      countdown_mid   = on_countdown_ff;
      off_mid         = off_minutes_ff;

      pending_call_in = pending_call_ff;
      pending_id_in   = pending_id_ff;
      on_countdown_in = on_countdown_ff;
      off_minutes_in  = off_minutes_ff;
      minute_count_in = minute_count_ff;

      call_latched_in = 1'b0;
      call_heard_in   = 1'b0;
      call_ignored_in = 1'b0;
      heard_id_in     = '0;
      switched_off_in = 1'b0;

      if (advance) begin
         unique case (s1_kind_ff)
            KIND_REPORT: begin
               // latest qualifying report replaces any pending one
               if (s1_percent_ff >= threshold) begin
                  pending_call_in = 1'b1;
                  pending_id_in   = s1_caller_id_ff;
                  call_latched_in = 1'b1;
               end
            end
            KIND_TICK: begin
               // consume the pending call
               if (pending_call_ff) begin
                  call_heard_in   = 1'b1;
                  heard_id_in     = pending_id_ff;
                  pending_call_in = 1'b0;
                  ignore = (on_countdown_ff == '0) && (off_minutes_ff <= off_limit);
                  if (ignore) begin
                     call_ignored_in = 1'b1;
                  end else begin
                     countdown_mid = on_load;
                     off_mid       = '0;
                  end
               end
               // run down the on time, or count off minutes
               if (countdown_mid != '0) begin
                  countdown_mid   = countdown_mid - CountdownWidth'(1);
                  switched_off_in = (countdown_mid == '0);
               end else if (s1_minute_start_ff && (off_mid != OFF_MAX)) begin
                  off_mid = off_mid + MinuteWidth'(1);
               end
               on_countdown_in = countdown_mid;
               off_minutes_in  = off_mid;
               if (s1_minute_start_ff) begin
                  minute_count_in = minute_count_ff + MinuteWidth'(1);
               end
            end
            default: ;
         endcase
      end
      boiler_on_in = (on_countdown_in != '0);
   end

   // result register loads on advance, clears when taken
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_on_minutes   <= 8'd0;
         cfg_ff.ticks_per_minute <= 6'd30;
         cfg_ff.low_threshold_pc <= 7'd50;
         cfg_ff.moderate_open_pc <= 7'd67;
         s1_valid_ff             <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         pending_call_ff         <= 1'b0;
         pending_id_ff           <= '0;
         on_countdown_ff         <= '0;
         off_minutes_ff          <= '0;
         minute_count_ff         <= '0;
      end else begin
         cfg_ff          <= cfg_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         pending_call_ff <= pending_call_in;
         pending_id_ff   <= pending_id_in;
         on_countdown_ff <= on_countdown_in;
         off_minutes_ff  <= off_minutes_in;
         minute_count_ff <= minute_count_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff         <= req_kind;
         s1_caller_id_ff    <= req_caller_id;
         s1_percent_ff      <= req_percent_open;
         s1_minute_start_ff <= req_minute_start;
      end
      if (advance) begin
         boiler_on_ff    <= boiler_on_in;
         call_latched_ff <= call_latched_in;
         call_heard_ff   <= call_heard_in;
         call_ignored_ff <= call_ignored_in;
         heard_id_ff     <= heard_id_in;
         switched_off_ff <= switched_off_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_boiler_on    = boiler_on_ff;
   assign rsp_call_latched = call_latched_ff;
   assign rsp_call_heard   = call_heard_ff;
   assign rsp_call_ignored = call_ignored_ff;
   assign rsp_heard_id     = heard_id_ff;
   assign rsp_switched_off = switched_off_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------

   // boiler running means off-minute counter was cleared by the load
   a_off_clear_while_on: assert property (@(posedge clock) disable iff (reset)
      (on_countdown_ff != '0) |-> (off_minutes_ff == '0))
      else $error("off minutes counted while boiler on");

   // an ignored call is always a heard call
   a_ignored_heard: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_call_ignored) |-> rsp_call_heard)
      else $error("ignored call not heard");

   // switching off leaves the boiler off
   a_switch_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_switched_off) |-> !rsp_boiler_on)
      else $error("switched off but boiler still on");

   // a processed tick always empties the pending call
   a_tick_consumes: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_kind_ff == KIND_TICK)) |=> !pending_call_ff)
      else $error("pending call survived a tick");

   // full input register and stalled result block new transactions
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while pipeline stalled");

endmodule

>>> src/bcfh_threshold.sv
// bcfh_threshold: percent-open threshold for valve reports from minute window and boiler state
// depends on bcfh_pkg (cfg_type, window constants)

module bcfh_threshold (
   input  bcfh_pkg::cfg_type                       cfg,
   input  logic [bcfh_pkg::MinuteWidth-1:0]        minute_count,
   input  logic                                    boiler_on,
   output logic [bcfh_pkg::PercentWidth-1:0]       threshold
);
   import bcfh_pkg::*;

   logic [5:0]              window;
   logic                    pause;
   logic                    encourage;
   logic [PercentWidth-1:0] moderate_less_one;
   logic [PercentWidth-1:0] strict;

   assign window    = minute_count[5:0];
   assign pause     = window < WINDOW_PAUSE_END;
   assign encourage = !pause && (window < WINDOW_ENCOURAGE_END);

   // moderate minus one, floored at zero
   assign moderate_less_one = (cfg.moderate_open_pc == '0) ? '0
                            : cfg.moderate_open_pc - PercentWidth'(1);
   assign strict = (moderate_less_one < cfg.low_threshold_pc) ? cfg.low_threshold_pc
                                                              : moderate_less_one;

   assign threshold = (!pause && (encourage || boiler_on)) ? cfg.low_threshold_pc : strict;

endmodule
